@@ rtl/baa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baa_pkg
// Shared types and constants for the bias add and activation block.
// ----------------------------------------------------------------------------
package baa_pkg;

  localparam int DATA_W      = 32;
  localparam int CH_W        = 10;
  localparam int MAX_CH      = 1024;
  localparam int POS_W       = 16;
  localparam int MODE_W      = 3;
  localparam int CLIP_W      = 31;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;

  // activation modes
  localparam logic [MODE_W-1:0] MODE_BIAS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELU  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RELU6 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LEAKY = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HSWSH = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_EN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK       = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HS_INV     = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HS_THR     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HS_OFF     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CH_LEN     = 8'd7;

  // request kinds on tuser
  localparam logic REQ_BIAS = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  typedef enum logic [1:0] {
    MUL_SLOPE_X,
    MUL_C_X,
    MUL_RES_INV
  } mul_sel_e;

  typedef struct packed {
    logic     take_bias;
    logic     take_data;
    logic     load_x;
    logic     load_prep;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     scale_en;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hswish;
    logic need_mul;
    logic out_free;
  } ctrl_status_t;

  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [2*DATA_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    logic                     all_one;
    logic                     all_zero;
    all_one  = &v[2*DATA_W-1:DATA_W-1];
    all_zero = ~|v[2*DATA_W-1:DATA_W-1];
    if (all_one || all_zero) begin
      r = v[DATA_W-1:0];
    end else if (v[2*DATA_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/bias_add_activation_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bias_add_activation_top
// Per-channel bias add and activation on a channel-major Q16.16 stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests. tuser 0 loads one bias table entry, tuser 1 is
//   the next tensor element; tlast flags the tensor's last element.
//   m_axis returns one result per element with its channel; tlast copies
//   the element's flag. Bias loads give no result.
//   cfg writes one register per request; cfg_ready_o is always high. Write
//   only while no element is in flight.
// Sequencing:
//   A bias load is taken while idle and does not stall the input. An element
//   is worked by a sequencer over one shared 32x32 multiplier: add, prep and
//   output states for bias, relu and relu6 and positive leaky inputs, with
//   one multiplier pass for negative or zero leaky inputs and two for
//   hardswish. No new element is taken until the last one is loaded out.
// Reset clears counters, config registers, output valid flag; the bias table
// must be loaded before use. When m_axis stalls, the finished result waits
// in the output register and the next element is still taken and worked;
// its result holds in the datapath until the output register frees.
// ----------------------------------------------------------------------------
module bias_add_activation_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: bias_index[9:0], bias_value[41:10], sample[73:42], zero pad
  input  logic [baa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: req_type
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tlast,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: result[31:0], channel_index[41:32], zero pad
  output logic [baa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [baa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [baa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import baa_pkg::*;

  ctrl_cmd_t                cmd;
  ctrl_status_t             status;
  logic signed [DATA_W-1:0] result;
  logic [CH_W-1:0]          channel_index;

  assign cfg_ready_o = 1'b1;

  baa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_kind_i  (s_axis_tuser),
    .req_ready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  baa_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .bias_index_i    (s_axis_tdata[CH_W-1:0]),
    .bias_value_i    (s_axis_tdata[CH_W+DATA_W-1:CH_W]),
    .sample_i        (s_axis_tdata[CH_W+2*DATA_W-1:CH_W+DATA_W]),
    .end_of_tensor_i (s_axis_tlast),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .result_o        (result),
    .channel_index_o (channel_index),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_TDATA_W-DATA_W-CH_W)'(0), channel_index, result};

endmodule

@@ rtl/baa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baa_ctrl
// Sequencer: accepts requests and steps the datapath through bias add,
// activation, shared multiplier passes and the output load.
// ----------------------------------------------------------------------------
module baa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_kind_i,
  output logic                  req_ready_o,
  input  baa_pkg::ctrl_status_t status_i,
  output baa_pkg::ctrl_cmd_t    cmd_o
);
  import baa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_PREP,
    ST_MUL,
    ST_SCALE,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          second_q <= 1'b0;
          if (req_valid_i && req_kind_i == REQ_DATA) state_q <= ST_ADD;
        end
        ST_ADD:  state_q <= ST_PREP;
        ST_PREP: state_q <= status_i.need_mul ? ST_MUL : ST_OUT;
        ST_MUL:  state_q <= ST_SCALE;
        ST_SCALE: begin
          if (status_i.hswish && !second_q) begin
            second_q <= 1'b1;
            state_q  <= ST_MUL;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (status_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MUL_SLOPE_X;
    cmd_o.take_bias = req_ready_o && req_valid_i && (req_kind_i == REQ_BIAS);
    cmd_o.take_data = req_ready_o && req_valid_i && (req_kind_i == REQ_DATA);
    cmd_o.load_x    = (state_q == ST_ADD);
    cmd_o.load_prep = (state_q == ST_PREP);
    cmd_o.mul_en    = (state_q == ST_MUL);
    cmd_o.scale_en  = (state_q == ST_SCALE);
    cmd_o.load_out  = (state_q == ST_OUT) && status_i.out_free;
    if (second_q) begin
      cmd_o.mul_sel = MUL_RES_INV;
    end else if (status_i.hswish) begin
      cmd_o.mul_sel = MUL_C_X;
    end
  end

endmodule

@@ rtl/baa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baa_datapath
// Configuration registers, bias table, element counters, saturating
// arithmetic with one shared multiplier, and the output register.
// ----------------------------------------------------------------------------
module baa_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [baa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [baa_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [baa_pkg::CH_W-1:0]            bias_index_i,
  input  logic signed [baa_pkg::DATA_W-1:0]   bias_value_i,
  input  logic signed [baa_pkg::DATA_W-1:0]   sample_i,
  input  logic                                end_of_tensor_i,
  input  baa_pkg::ctrl_cmd_t                  cmd_i,
  output baa_pkg::ctrl_status_t               status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [baa_pkg::DATA_W-1:0]   result_o,
  output logic [baa_pkg::CH_W-1:0]            channel_index_o,
  output logic                                last_o
);
  import baa_pkg::*;

  // configuration
  logic [MODE_W-1:0]        act_mode_q;
  logic                     bias_en_q;
  logic [CLIP_W-1:0]        clip_q;
  logic signed [DATA_W-1:0] leak_q;
  logic signed [DATA_W-1:0] hs_inv_q;
  logic signed [DATA_W-1:0] hs_thr_q;
  logic signed [DATA_W-1:0] hs_off_q;
  logic [POS_W-1:0]         ch_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_mode_q <= MODE_BIAS;
      bias_en_q  <= 1'b0;
      clip_q     <= 31'd393216;
      leak_q     <= 32'sd6554;
      hs_inv_q   <= 32'sd10923;
      hs_thr_q   <= 32'sd393216;
      hs_off_q   <= 32'sd196608;
      ch_len_q   <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ACT_MODE: act_mode_q <= cfg_data_i[MODE_W-1:0];
        REG_BIAS_EN:  bias_en_q  <= cfg_data_i[0];
        REG_CLIP:     clip_q     <= cfg_data_i[CLIP_W-1:0];
        REG_LEAK:     leak_q     <= cfg_data_i[DATA_W-1:0];
        REG_HS_INV:   hs_inv_q   <= cfg_data_i[DATA_W-1:0];
        REG_HS_THR:   hs_thr_q   <= cfg_data_i[DATA_W-1:0];
        REG_HS_OFF:   hs_off_q   <= cfg_data_i[DATA_W-1:0];
        REG_CH_LEN:   ch_len_q   <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // bias table
  logic signed [DATA_W-1:0] bias_mem [MAX_CH];
  logic signed [DATA_W-1:0] bias_q;

  // element counters
  logic [POS_W-1:0] pos_q;
  logic [CH_W-1:0]  ch_q;
  logic [POS_W:0]   pos_inc;

  assign pos_inc = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_bias && ({1'b0, bias_index_i} < (CH_W+1)'(MAX_CH))) begin
      bias_mem[bias_index_i] <= bias_value_i;
    end
    if (cmd_i.take_data) begin
      bias_q <= bias_mem[ch_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ch_q  <= '0;
    end else if (cmd_i.take_data) begin
      if (end_of_tensor_i) begin
        pos_q <= '0;
        ch_q  <= '0;
      end else if (pos_inc >= {1'b0, ch_len_q}) begin
        pos_q <= '0;
        ch_q  <= (ch_q == CH_W'(MAX_CH - 1)) ? '0 : ch_q + 1'b1;
      end else begin
        pos_q <= pos_inc[POS_W-1:0];
      end
    end
  end

  // item registers
  logic signed [DATA_W-1:0]   sample_q;
  logic [CH_W-1:0]            item_ch_q;
  logic                       item_last_q;
  logic signed [DATA_W-1:0]   x_q;
  logic signed [DATA_W-1:0]   c_q;
  logic signed [DATA_W-1:0]   res_q;
  logic signed [2*DATA_W-1:0] prod_q;

  logic                       use_bias;
  logic signed [DATA_W-1:0]   x_d;
  logic signed [DATA_W-1:0]   off_sum;
  logic signed [DATA_W-1:0]   c_d;
  logic signed [DATA_W-1:0]   clip_s;
  logic signed [DATA_W-1:0]   simple_res;
  logic signed [DATA_W-1:0]   op_a;
  logic signed [DATA_W-1:0]   op_b;
  logic signed [2*DATA_W-1:0] prod_shift;

  assign use_bias = bias_en_q && (act_mode_q <= MODE_HSWSH);
  assign x_d = use_bias ? sat_sum({sample_q[DATA_W-1], sample_q} + {bias_q[DATA_W-1], bias_q})
                        : sample_q;
  assign off_sum = sat_sum({x_q[DATA_W-1], x_q} + {hs_off_q[DATA_W-1], hs_off_q});
  assign clip_s  = {1'b0, clip_q};

  always_comb begin
    c_d = off_sum[DATA_W-1] ? '0 : off_sum;
    if (c_d > hs_thr_q) c_d = hs_thr_q;
  end

  always_comb begin
    simple_res = x_q;
    case (act_mode_q)
      MODE_RELU:  simple_res = x_q[DATA_W-1] ? '0 : x_q;
      MODE_RELU6: begin
        if (x_q[DATA_W-1]) begin
          simple_res = '0;
        end else if (x_q > clip_s) begin
          simple_res = clip_s;
        end
      end
      default: simple_res = x_q;
    endcase
  end

  always_comb begin
    op_a = leak_q;
    op_b = x_q;
    case (cmd_i.mul_sel)
      MUL_C_X: begin
        op_a = c_q;
        op_b = x_q;
      end
      MUL_RES_INV: begin
        op_a = res_q;
        op_b = hs_inv_q;
      end
      default: begin
        op_a = leak_q;
        op_b = x_q;
      end
    endcase
  end

  assign prod_shift = prod_q >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_data) begin
      sample_q    <= sample_i;
      item_ch_q   <= ch_q;
      item_last_q <= end_of_tensor_i;
    end
    if (cmd_i.load_x) x_q <= x_d;
    if (cmd_i.load_prep) begin
      c_q   <= c_d;
      res_q <= simple_res;
    end
    if (cmd_i.mul_en) prod_q <= (2*DATA_W)'(op_a) * (2*DATA_W)'(op_b);
    if (cmd_i.scale_en) res_q <= sat_wide(prod_shift);
  end

  // output register
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_res_q;
  logic [CH_W-1:0]          out_ch_q;
  logic                     out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_res_q  <= res_q;
      out_ch_q   <= item_ch_q;
      out_last_q <= item_last_q;
    end
  end

  assign status_o.hswish   = (act_mode_q == MODE_HSWSH);
  assign status_o.need_mul = (act_mode_q == MODE_HSWSH) ||
                             ((act_mode_q == MODE_LEAKY) && (x_q[DATA_W-1] || x_q == '0));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign result_o        = out_res_q;
  assign channel_index_o = out_ch_q;
  assign last_o          = out_last_q;

endmodule

@@ rtl/baa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baa_checker
// Port-level checks for the bias add and activation block.
// ----------------------------------------------------------------------------
module baa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tuser,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [baa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready
);
  import baa_pkg::*;

  logic take_data;
  logic take_bias;

  assign take_data = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_DATA);
  assign take_bias = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_BIAS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_data |=> !s_axis_tready)
    else $error("element request taken while one is in work");

  a_bias_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_bias |=> s_axis_tready)
    else $error("bias load stalled the input");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_data |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind bias_add_activation_top baa_checker u_baa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fused bias add and activation stream block.
// Drives bias-table loads and tensor elements on s_axis, predicts every
// element's result, channel and tensor-end flag with a model of its own, and
// compares each m_axis result against the oldest prediction. Covers every
// activation mode, saturation at the data extremes, register corners, the
// channel counter wrapping, output backpressure and random traffic under
// several idle and stall profiles.
// ----------------------------------------------------------------------------
module tb_top;
  import baa_pkg::*;

  localparam int          FRAC_BITS     = 16;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          MAX_REPORTS   = 10;
  localparam longint      Q_MAX         = 64'sh7FFF_FFFF;
  localparam longint      Q_MIN         = -64'sh8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [CH_W-1:0]   channel;
    logic              last;
  } act_out_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  bias_add_activation_top #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor state
  logic [DATA_W-1:0]        bias_mem    [MAX_CH];
  bit                       bias_loaded [MAX_CH];
  logic [POS_W-1:0]         elem_pos = '0;
  logic [CH_W-1:0]          cur_ch   = '0;
  logic [MODE_W-1:0]        r_mode   = MODE_BIAS;
  logic                     r_bias_en = 1'b0;
  logic [CLIP_W-1:0]        r_clip   = 31'd393216;
  logic signed [DATA_W-1:0] r_slope  = 32'sd6554;
  logic signed [DATA_W-1:0] r_inv    = 32'sd10923;
  logic signed [DATA_W-1:0] r_thr    = 32'sd393216;
  logic signed [DATA_W-1:0] r_off    = 32'sd196608;
  logic [POS_W-1:0]         r_chlen  = 16'd1;

  act_out_t    pending_outputs [$];
  int unsigned mismatches   = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_req  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint sat_q(longint v);
    longint r;
    r = v;
    if (v > Q_MAX) r = Q_MAX;
    if (v < Q_MIN) r = Q_MIN;
    return r;
  endfunction

  function automatic longint mul_q(longint a, longint b);
    longint p;
    p = a * b;
    return sat_q(p >>> FRAC_BITS);
  endfunction

  function automatic act_out_t predict_element(logic [DATA_W-1:0] smp, logic eot);
    act_out_t o;
    longint   x;
    longint   c;
    x = longint'($signed(smp));
    if (r_mode <= MODE_HSWSH && r_bias_en) begin
      x = sat_q(x + longint'($signed(bias_mem[cur_ch])));
    end
    case (r_mode)
      MODE_RELU: begin
        if (x < 0) x = 0;
      end
      MODE_RELU6: begin
        if (x < 0) x = 0;
        if (x > longint'(r_clip)) x = longint'(r_clip);
      end
      MODE_LEAKY: begin
        if (x <= 0) x = mul_q(longint'(r_slope), x);
      end
      MODE_HSWSH: begin
        c = sat_q(x + longint'(r_off));
        if (c < 0) c = 0;
        if (c > longint'(r_thr)) c = longint'(r_thr);
        x = mul_q(mul_q(c, x), longint'(r_inv));
      end
      default: ;
    endcase
    o.value   = x[DATA_W-1:0];
    o.channel = cur_ch;
    o.last    = eot;
    if (eot) begin
      elem_pos = '0;
      cur_ch   = '0;
    end else if ({16'd0, elem_pos} + 32'd1 >= {16'd0, r_chlen}) begin
      elem_pos = '0;
      cur_ch   = cur_ch + 1'b1;
    end else begin
      elem_pos = elem_pos + 1'b1;
    end
    return o;
  endfunction

  function automatic logic [DATA_W-1:0] rand_q();
    logic [DATA_W-1:0] r;
    case ($urandom_range(3))
      0: r = $urandom;
      1: r = 32'($urandom_range(0, 32'h10_0000)) - 32'h8_0000;
      2: r = 32'($urandom_range(0, 32'h2_0000)) - 32'h1_0000;
      default: begin
        case ($urandom_range(3))
          0: r = 32'h7FFF_FFFF;
          1: r = 32'h8000_0000;
          2: r = '0;
          default: r = '1;
        endcase
      end
    endcase
    return r;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    act_out_t want;
    act_out_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value   = m_axis_tdata[DATA_W-1:0];
      got.channel = m_axis_tdata[DATA_W+CH_W-1:DATA_W];
      got.last    = m_axis_tlast;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: value %h channel %0d last %0b",
                   got.value, got.channel, got.last);
        end
      end else begin
        want = pending_outputs.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected %h ch %0d last %0b, actual %h ch %0d last %0b",
                     want.value, want.channel, want.last,
                     got.value, got.channel, got.last);
          end
        end
      end
    end
  end

  task automatic send_request(input logic req, input logic [CH_W-1:0] idx,
                              input logic [DATA_W-1:0] bval,
                              input logic [DATA_W-1:0] smp, input logic eot);
    int unsigned gap;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, smp, bval, idx};
    s_axis_tuser  <= req;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    if (req == REQ_DATA) begin
      pending_outputs.push_back(predict_element(smp, eot));
    end else begin
      bias_mem[idx]    = bval;
      bias_loaded[idx] = 1'b1;
    end
  endtask

  task automatic send_bias(input logic [CH_W-1:0] idx, input logic [DATA_W-1:0] bval);
    send_request(REQ_BIAS, idx, bval, $urandom, 1'($urandom_range(1)));
  endtask

  // load the channel's bias first if it was never written
  task automatic send_element(input logic [DATA_W-1:0] smp, input logic eot);
    if (!bias_loaded[cur_ch]) send_bias(cur_ch, rand_q());
    send_request(REQ_DATA, 10'($urandom), $urandom, smp, eot);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ACT_MODE: r_mode    = data[MODE_W-1:0];
      REG_BIAS_EN:  r_bias_en = data[0];
      REG_CLIP:     r_clip    = data[CLIP_W-1:0];
      REG_LEAK:     r_slope   = data;
      REG_HS_INV:   r_inv     = data;
      REG_HS_THR:   r_thr     = data;
      REG_HS_OFF:   r_off     = data;
      REG_CH_LEN:   r_chlen   = data[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] mode, input logic [31:0] bias_en,
                            input logic [31:0] clip, input logic [31:0] slope,
                            input logic [31:0] inv, input logic [31:0] thr,
                            input logic [31:0] off, input logic [31:0] chlen);
    write_reg(REG_ACT_MODE, mode);
    write_reg(REG_BIAS_EN, bias_en);
    write_reg(REG_CLIP, clip);
    write_reg(REG_LEAK, slope);
    write_reg(REG_HS_INV, inv);
    write_reg(REG_HS_THR, thr);
    write_reg(REG_HS_OFF, off);
    write_reg(REG_CH_LEN, chlen);
    cfg_valid_i <= 1'b0;
  endtask

  // drop valid, wait out all results, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_element(32'h7FFF_FFFF, 1'b0);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'h0000_0000, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_modes();
    drain();
    write_reg(8'd8, $urandom);
    write_reg(8'hFF, $urandom);
    set_config(MODE_BIAS, 1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'hFFFF_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
    send_bias(10'd0, 32'h7FFF_FFFF);
    send_bias(10'd1, 32'h8000_0000);
    send_bias(10'd2, 32'h0001_8000);
    for (int m = 0; m < 8; m++) begin
      drain();
      set_config(m, 1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hFFFF_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
      send_element(32'h7FFF_FFFF, 1'b0);
      send_element(32'h8000_0000, 1'b0);
      send_element(32'hFFFF_0000, 1'b1);
    end
  endtask

  task automatic test_long_channel();
    drain();
    set_config(MODE_RELU6, 0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
               32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF);
    for (int i = 0; i < 6; i++) send_element(rand_q(), i == 3);
  endtask

  task automatic test_channel_wrap();
    int unsigned tx_set [4] = '{0, 61, 0, 33};
    int unsigned rx_set [4] = '{0, 0, 61, 33};
    drain();
    set_config(MODE_LEAKY, 0, 32'd393216, 32'd6554, 32'd10923, 32'd393216,
               32'd196608, 32'd1);
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_set[ph];
      rx_stall_pct = rx_set[ph];
      for (int i = 0; i < 257; i++) begin
        send_request(REQ_DATA, 10'($urandom), $urandom, rand_q(), ph == 3 && i == 256);
      end
    end
  endtask

  task automatic test_backpressure();
    drain();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_config(MODE_HSWSH, 1, 32'd393216, 32'd6554, 32'd10923, 32'd393216,
               32'd196608, 32'd3);
    rx_hold_req = 300;
    for (int i = 0; i < 40; i++) send_element(rand_q(), i == 39);
  endtask

  task automatic test_random();
    int unsigned tx_set [4] = '{0, 61, 0, 33};
    int unsigned rx_set [4] = '{0, 0, 61, 33};
    int unsigned m;
    int unsigned len;
    logic [31:0] inv;
    logic [31:0] thr;
    logic [31:0] off;
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 2; k++) begin
        drain();
        tx_idle_pct  = tx_set[ph];
        rx_stall_pct = rx_set[ph];
        m = $urandom_range(0, 11);
        if (m > 7) m = m - 7;
        inv = rand_q();
        thr = rand_q();
        off = rand_q();
        if (m == MODE_HSWSH && $urandom_range(1)) begin
          off = 32'h0003_0000;
          thr = 32'h0006_0000;
          inv = 32'd10923;
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
        set_config((32'($urandom) & ~32'h7) | m, $urandom, rand_q(), rand_q(),
                   inv, thr, off, {16'($urandom), 16'(len)});
        for (int n = 0; n < 8; n++) begin
          if ($urandom_range(99) < 15) begin
            send_bias(10'($urandom), rand_q());
          end else begin
            send_element(rand_q(), $urandom_range(99) < 5);
          end
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_modes();
    test_long_channel();
    test_channel_wrap();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
